[design/tsip_keyed_hash64_assert.svh]
// ---------------------------------------------------------------------------
// tsip_keyed_hash64_assert.svh
// Assertion macros shared by the keyed hash modules.
// ---------------------------------------------------------------------------
`ifndef TSIP_KEYED_HASH64_ASSERT_SVH
`define TSIP_KEYED_HASH64_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property holds at every clock edge outside reset.
`define TKH_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("tkh assertion failed");

// Expression never true outside reset.
`define TKH_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("tkh forbidden condition");

`else

`define TKH_ASSERT(label, clk, rst, prop)
`define TKH_NEVER(label, clk, rst, expr)

`endif

`endif

[design/tkh64_pkg.sv]
// ---------------------------------------------------------------------------
// tkh64_pkg
// Types, constants and round functions of the keyed 64-bit hash.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tkh64_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned TAIL_W      = 3;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned OUT_DEPTH   = 8;

  // register indexes on the config port
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_HIGH = 8'd1;

  localparam logic [WORD_W-1:0] LANE_A_CONST = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] LANE_B_CONST = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] FINAL_MARK   = 64'h00000000000000ff;
  localparam logic [LEN_W-1:0]  BODY_BYTES   = 8'd8;

  localparam int unsigned ROT_B1  = 13;
  localparam int unsigned ROT_A1  = 35;
  localparam int unsigned ROT_B2  = 17;
  localparam int unsigned ROT_A2  = 21;
  localparam int unsigned ROT_FIN = 32;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } lanes_t;

  // handoff from the lane stage to the finalization pipe
  typedef struct packed {
    logic   valid;
    lanes_t lanes;
  } fin_req_t;

  function automatic logic [WORD_W-1:0] rol64(input logic [WORD_W-1:0] x,
                                              input int unsigned k);
    return (x << k) | (x >> (WORD_W - k));
  endfunction

  // one add-rotate-xor compression round
  function automatic lanes_t compress(input lanes_t s);
    lanes_t r;
    r.a = s.a + s.b;
    r.b = rol64(s.b, ROT_B1) ^ r.a;
    r.a = rol64(r.a, ROT_A1) + r.b;
    r.b = rol64(r.b, ROT_B2) ^ r.a;
    r.a = rol64(r.a, ROT_A2);
    return r;
  endfunction

  // finalization round: compress, then swap lane_b halves
  function automatic lanes_t fin_round(input lanes_t s);
    lanes_t r;
    r   = compress(s);
    r.b = rol64(r.b, ROT_FIN);
    return r;
  endfunction

  function automatic lanes_t seed_lanes(input logic [WORD_W-1:0] lo,
                                        input logic [WORD_W-1:0] hi);
    lanes_t r;
    r.a = lo ^ LANE_A_CONST;
    r.b = hi ^ LANE_B_CONST;
    return r;
  endfunction

endpackage

`default_nettype wire

[design/tsip_keyed_hash64.sv]
// ---------------------------------------------------------------------------
// tsip_keyed_hash64
// Keyed 64-bit hash, two-lane add-rotate-xor compression.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: s_tdata carries one 8-byte little-endian message word,
//   s_tlast marks the final request, s_tuser gives its tail byte count
//   (0..7, unused on body words). Master stream: m_tdata is the hash, one
//   per final request. Config channel: index 0 writes seed_low, index 1
//   seed_high; any seed write restarts the message. Write seeds only while
//   no message is in progress or pending.
// Timing:
//   One request per cycle on both streams while s_tready and m_tready are high.
//   A final request passes the input register, lane stage, two registered
//   finalization rounds, the third round into the queue and the queue count
//   to reach m_tvalid. Lanes do one compression per cycle while taking words.
// Reset: seeds clear to zero, lanes load from the zero seed, queue empties.
// Stall: finished hashes wait in an 8-entry queue; s_tready drops only
//   while 8 hashes are in flight or queued, until then body words keep flowing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsip_keyed_hash64
  import tkh64_pkg::*;
#(
  parameter int unsigned OUT_QUEUE_DEPTH = OUT_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // slave stream
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [WORD_W-1:0]      s_tdata,   // [63:0] data_word
  input  wire logic [TAIL_W-1:0]      s_tuser,   // [2:0] tail_bytes
  input  wire logic                   s_tlast,
  // master stream
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [WORD_W-1:0]           m_tdata,   // [63:0] hash_value
  // config write
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data
);

  logic              take;
  logic              room;
  fin_req_t          fin;
  logic              hash_valid;
  logic [WORD_W-1:0] hash;

  assign cfg_ready = 1'b1;
  assign s_tready  = room;
  assign take      = s_tvalid && room;

  tkh64_lanes u_lanes (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_take   (take),
    .in_word   (s_tdata),
    .in_tail   (s_tuser),
    .in_last   (s_tlast),
    .fin       (fin)
  );

  tkh64_final u_final (
    .clk        (clk),
    .rst        (rst),
    .fin        (fin),
    .hash_valid (hash_valid),
    .hash       (hash)
  );

  tkh64_out_fifo #(
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .reserve  (take && s_tlast),
    .room     (room),
    .wr       (hash_valid),
    .wr_data  (hash),
    .rd_valid (m_tvalid),
    .rd_ready (m_tready),
    .rd_data  (m_tdata)
  );

endmodule

`default_nettype wire

[design/tkh64_lanes.sv]
// ---------------------------------------------------------------------------
// tkh64_lanes
// Seed registers, input register and lane state. Absorbs one word per cycle
// while words are taken; a final word goes to the finalization pipe and the
// lanes reload from the seed. A seed write wins and reloads from the new seed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tsip_keyed_hash64_assert.svh"

module tkh64_lanes
  import tkh64_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config write
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]      cfg_data,
  // accepted input request
  input  wire logic                   in_take,
  input  wire logic [WORD_W-1:0]      in_word,
  input  wire logic [TAIL_W-1:0]      in_tail,
  input  wire logic                   in_last,
  // to finalization
  output fin_req_t                    fin
);

  logic [WORD_W-1:0] seed_low;
  logic [WORD_W-1:0] seed_high;
  logic              hit_low;
  logic              hit_high;
  logic [WORD_W-1:0] seed_low_next;
  logic [WORD_W-1:0] seed_high_next;

  // input register
  logic              iv;
  logic [WORD_W-1:0] iword;
  logic [TAIL_W-1:0] itail;
  logic              ilast;

  lanes_t            lanes;
  lanes_t            lanes_next;
  logic [LEN_W-1:0]  length_low;
  logic [LEN_W-1:0]  length_low_next;

  logic [WORD_W-LEN_W-1:0] keep;
  logic [LEN_W-1:0]  total;
  logic [WORD_W-1:0] absorb_w;
  lanes_t            mixed;
  fin_req_t          fin_next;

  // seed decode
  always_comb begin
    hit_low        = cfg_write && (cfg_index == REG_SEED_LOW);
    hit_high       = cfg_write && (cfg_index == REG_SEED_HIGH);
    seed_low_next  = hit_low  ? cfg_data : seed_low;
    seed_high_next = hit_high ? cfg_data : seed_high;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_low  <= '0;
      seed_high <= '0;
    end else begin
      seed_low  <= seed_low_next;
      seed_high <= seed_high_next;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else begin
      iv <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      iword <= in_word;
      itail <= in_tail;
      ilast <= in_last;
    end
  end

  // tail packing: keep bytes below the tail count, length in the top byte
  always_comb begin
    for (int i = 0; i < (WORD_W - LEN_W) / 8; i++) begin
      keep[8*i +: 8] = (i < int'(itail)) ? 8'hff : 8'h00;
    end
    total = length_low + LEN_W'(itail);
    if (ilast) begin
      absorb_w = {total, iword[WORD_W-LEN_W-1:0] & keep};
    end else begin
      absorb_w = iword;
    end
  end

  // absorb and next lane state
  always_comb begin
    lanes_t pre;
    pre          = lanes;
    pre.b        = lanes.b ^ absorb_w;
    mixed        = compress(pre);
    mixed.a      = mixed.a ^ absorb_w;
    lanes_next      = lanes;
    length_low_next = length_low;
    fin_next.valid  = 1'b0;
    fin_next.lanes  = mixed;
    fin_next.lanes.b = mixed.b ^ FINAL_MARK;
    if (hit_low || hit_high) begin
      lanes_next      = seed_lanes(seed_low_next, seed_high_next);
      length_low_next = '0;
    end else if (iv && ilast) begin
      lanes_next      = seed_lanes(seed_low, seed_high);
      length_low_next = '0;
      fin_next.valid  = 1'b1;
    end else if (iv) begin
      lanes_next      = mixed;
      length_low_next = length_low + BODY_BYTES;
    end
  end

  // lane state and handoff to finalization
  always_ff @(posedge clk) begin
    fin.lanes <= fin_next.lanes;
    if (rst) begin
      lanes      <= seed_lanes('0, '0);
      length_low <= '0;
      fin.valid  <= 1'b0;
    end else begin
      lanes      <= lanes_next;
      length_low <= length_low_next;
      fin.valid  <= fin_next.valid;
    end
  end

  // a seed write restarts the message
  `TKH_ASSERT(a_cfg_clears_len, clk, rst,
              (hit_low || hit_high) |=> (length_low == '0))
  // a final word with no config write beside it launches exactly one finalization
  `TKH_ASSERT(a_last_launches, clk, rst,
              (iv && ilast && !cfg_write) |=> fin.valid)

endmodule

`default_nettype wire

[design/tkh64_final.sv]
// ---------------------------------------------------------------------------
// tkh64_final
// Finalization pipe: two registered rounds, a combinational third, then lane_a ^ lane_b.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tsip_keyed_hash64_assert.svh"

module tkh64_final
  import tkh64_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  fin_req_t               fin,
  output logic                   hash_valid,
  output logic [WORD_W-1:0]      hash
);

  logic   s2_valid;
  logic   s3_valid;
  lanes_t s2;
  lanes_t s3;
  lanes_t last_round;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= fin.valid;
      s3_valid <= s2_valid;
    end
  end

  // one round per stage
  always_ff @(posedge clk) begin
    s2 <= fin_round(fin.lanes);
    s3 <= fin_round(s2);
  end

  always_comb begin
    last_round = fin_round(s3);
    hash_valid = s3_valid;
    hash       = last_round.a ^ last_round.b;
  end

  `TKH_ASSERT(a_pipe_moves, clk, rst, fin.valid |=> ##1 hash_valid)

endmodule

`default_nettype wire

[design/tkh64_out_fifo.sv]
// ---------------------------------------------------------------------------
// tkh64_out_fifo
// Result queue with credit count. Credits cover hashes still in the pipe,
// so the queue can never overflow and the pipe never stalls.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "tsip_keyed_hash64_assert.svh"

module tkh64_out_fifo
  import tkh64_pkg::*;
#(
  parameter int unsigned DEPTH = OUT_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              reserve,
  output logic                   room,
  input  wire logic              wr,
  input  wire logic [WORD_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic [WORD_W-1:0]      rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  credits;
  logic              pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = (fill != '0);
  assign rd_data  = mem[rd_ptr];
  assign room     = (credits < CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      fill    <= '0;
      credits <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      fill    <= fill + CNT_W'(wr) - CNT_W'(pop);
      credits <= credits + CNT_W'(reserve) - CNT_W'(pop);
    end
  end

  `TKH_NEVER(a_no_overflow, clk, rst, wr && !pop && (fill == CNT_W'(DEPTH)))
  `TKH_ASSERT(a_fill_in_credit, clk, rst, fill <= credits)

endmodule

`default_nettype wire
